// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files, used by the point sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pcop_pkg.sv =====
// Package: types, register codes and the sine table builder for the circle point block.
`timescale 1ns / 1ps
`default_nettype none
package pcop_pkg;

  localparam int ANGLE_W  = 7;
  localparam int COORD_W  = 12;
  localparam int RADIUS_W = 11;
  localparam int POINT_W  = 14;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int TAB_W    = 25;   // widest sine word: 24 fraction bits plus the unit bit

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 7'd90;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_CENTRE_X = 2'd0;
  localparam logic [1:0] REG_CENTRE_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic [RADIUS_W-1:0]       circle_radius;
  } pcop_cfg_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] dx;
    logic [RADIUS_W-1:0] dy;
  } pcop_delta_t;

  typedef logic [90:0][TAB_W-1:0] sin_tab_t;

  // Sine of 0..90 degrees, elaboration only: Q2.30 Taylor series to t^17,
  // truncating products and quotients, clamped to [0, 1], then rounded to
  // frac_bits fraction bits with halves going up.
  function automatic sin_tab_t sin_tab(input int frac_bits);
    sin_tab_t           tab;
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    tab = '0;
    for (int d = 0; d <= 90; d++) begin
      t    = (64'(d) * 64'd3373259426 + 64'd90) / 64'd180;
      t2   = (t * t) >> 30;
      term = t;
      sum  = $signed(t);
      for (int k = 1; k <= 8; k++) begin
        term = (term * t2) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      v = $unsigned(sum);
      if (v > 64'd1073741824) begin
        v = 64'd1073741824;
      end
      v = (v + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
      tab[d] = v[TAB_W-1:0];
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pcop_ifs.sv =====
// Handshake interfaces: angle requests in, plotted points out.
`timescale 1ns / 1ps
`default_nettype none
interface pcop_angle_if;
  import pcop_pkg::*;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_degrees;
  modport source (output valid, output angle_degrees, input ready);
  modport sink (input valid, input angle_degrees, output ready);
endinterface

interface pcop_point_if;
  import pcop_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;
  logic                      last_point;
  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pcop_apb_regs.sv =====
// APB configuration registers: centre and radius.
`timescale 1ns / 1ps
`default_nettype none
module pcop_apb_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pcop_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pcop_pkg::DATA_W-1:0] pwdata,
  output logic      [pcop_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output pcop_pkg::pcop_cfg_t              cfg
);
  import pcop_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CENTRE_X: cfg.centre_x      <= pwdata[COORD_W-1:0];
        REG_CENTRE_Y: cfg.centre_y      <= pwdata[COORD_W-1:0];
        REG_RADIUS:   cfg.circle_radius <= pwdata[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CENTRE_X: prdata = DATA_W'($unsigned(cfg.centre_x));
      REG_CENTRE_Y: prdata = DATA_W'($unsigned(cfg.centre_y));
      REG_RADIUS:   prdata = DATA_W'(cfg.circle_radius);
      default:      prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/pcop_trig_scale.sv =====
// Four-stage pipe: angle clamp, sine lookup, radius multiply, rounding.
`timescale 1ns / 1ps
`default_nettype none
module pcop_trig_scale #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pcop_angle_if.sink                         angle,
  input  wire logic [pcop_pkg::RADIUS_W-1:0] circle_radius,
  output logic                               delta_valid,
  input  wire logic                          delta_ready,
  output pcop_pkg::pcop_delta_t              delta
);
  import pcop_pkg::*;

  localparam int SIN_W  = TRIG_FRAC_BITS + 1;
  localparam int PROD_W = RADIUS_W + SIN_W;
  localparam sin_tab_t SIN_TAB = sin_tab(TRIG_FRAC_BITS);
  localparam logic [TRIG_FRAC_BITS-1:0] HALF = {1'b1, {(TRIG_FRAC_BITS-1){1'b0}}};

  logic                v0, v1, v2, v3;
  logic                rdy0, rdy1, rdy2, rdy3;
  logic [ANGLE_W-1:0]  ang0;
  logic [SIN_W-1:0]    sin_x1, sin_y1;
  logic [PROD_W-1:0]   prod_x2, prod_y2;
  logic [RADIUS_W-1:0] dx_rnd, dy_rnd;
  pcop_delta_t         delta3;

  assign rdy3 = !v3 || delta_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign angle.ready = rdy0;

  // round up only when the fraction is strictly above one half
  always_comb begin
    dx_rnd = RADIUS_W'(prod_x2[PROD_W-1:TRIG_FRAC_BITS])
           + RADIUS_W'(prod_x2[TRIG_FRAC_BITS-1:0] > HALF);
    dy_rnd = RADIUS_W'(prod_y2[PROD_W-1:TRIG_FRAC_BITS])
           + RADIUS_W'(prod_y2[TRIG_FRAC_BITS-1:0] > HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) v0 <= angle.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      ang0 <= (angle.angle_degrees > ANGLE_MAX) ? ANGLE_MAX : angle.angle_degrees;
    end
    if (rdy1) begin
      sin_x1 <= SIN_TAB[ANGLE_MAX - ang0][SIN_W-1:0];
      sin_y1 <= SIN_TAB[ang0][SIN_W-1:0];
    end
    if (rdy2) begin
      prod_x2 <= PROD_W'(circle_radius) * PROD_W'(sin_x1);
      prod_y2 <= PROD_W'(circle_radius) * PROD_W'(sin_y1);
    end
    if (rdy3) begin
      delta3.dx <= dx_rnd;
      delta3.dy <= dy_rnd;
    end
  end

  assign delta_valid = v3;
  assign delta       = delta3;
endmodule
`default_nettype wire

// ===== rtl/core/pcop_point_seq.sv =====
// Point sequencer: mirrors one (dx, dy) into eight points through an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pcop_point_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                delta_valid,
  output logic                     delta_ready,
  input  wire pcop_pkg::pcop_delta_t delta,
  input  wire pcop_pkg::pcop_cfg_t   cfg,
  pcop_point_if.source             point
);
  import pcop_pkg::*;

  logic                      busy;
  logic [2:0]                cnt;
  logic [RADIUS_W-1:0]       dx, dy;
  logic                      ovalid;
  logic signed [POINT_W-1:0] ox, oy;
  logic                      olast;
  logic                      adv, take;
  logic [RADIUS_W-1:0]       a, b;
  logic signed [POINT_W-1:0] cx, cy, ax, by;
  logic signed [POINT_W-1:0] x_next, y_next;

  assign adv         = busy && (!ovalid || point.ready);
  assign delta_ready = !busy || (adv && cnt == 3'd7);
  assign take        = delta_valid && delta_ready;

  // cnt[2] swaps the axes, cnt[0] picks +x, cnt[1] picks -y
  always_comb begin
    a      = cnt[2] ? dy : dx;
    b      = cnt[2] ? dx : dy;
    cx     = POINT_W'(cfg.centre_x);
    cy     = POINT_W'(cfg.centre_y);
    ax     = $signed(POINT_W'(a));
    by     = $signed(POINT_W'(b));
    x_next = cnt[0] ? cx + ax : cx - ax;
    y_next = cnt[1] ? cy - by : cy + by;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= 3'd0;
      ovalid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (adv) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) busy <= 1'b0;
      end
      if (adv) begin
        ovalid <= 1'b1;
      end else if (point.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dx <= delta.dx;
      dy <= delta.dy;
    end
    if (adv) begin
      ox    <= x_next;
      oy    <= y_next;
      olast <= (cnt == 3'd7);
    end
  end

  assign point.valid      = ovalid;
  assign point.point_x    = ox;
  assign point.point_y    = oy;
  assign point.last_point = olast;

  `ASSERT_NEXT(a_take_starts, clk, rst, take, busy && cnt == 3'd0, "new delta did not start at point 0")
  `ASSERT_NEXT(a_hold_count, clk, rst, busy && !adv, busy && $stable(cnt), "point count moved while stalled")
  `ASSERT_NEXT(a_last_ends, clk, rst, adv && cnt == 3'd7 && !take, !busy, "sequencer ran past the eighth point")
endmodule
`default_nettype wire

// ===== rtl/core/parametric_circle_octant_points.sv =====
// Top level: circle octant point generator with APB configuration.
// Usage:
//   angle  - request channel (valid/ready) carrying angle_degrees, a whole
//            degree 46..90; values above 90 are treated as 90.
//   point  - result channel (valid/ready) carrying point_x, point_y and
//            last_point; every angle request yields eight points in mirror
//            order, last_point high on the eighth.
//   APB    - centre_x at 0x0, centre_y at 0x4, circle_radius at 0x8; write
//            only while no request is in flight. pready is tied high.
// Path: a request passes the clamp, sine lookup, multiply and round registers,
//   then the sequencer load and the point output register before its first point.
// Flow: the single point output issues eight points per request, and the sequencer
//   takes the next request as it issues the eighth; the front pipe accepts a
//   request every cycle until it backs up behind the sequencer.
// Reset (rst, synchronous): clears all valid bits and the configuration registers to 0.
// Stall: when point.ready is low the output register holds, the sequencer
//   waits and the pipe fills and drops angle.ready; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
module parametric_circle_octant_points #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pcop_angle_if.sink                       angle,
  pcop_point_if.source                     point,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pcop_pkg::ADDR_W-1:0] paddr,
  input  wire logic [pcop_pkg::DATA_W-1:0] pwdata,
  output logic      [pcop_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import pcop_pkg::*;

  pcop_cfg_t   cfg;
  pcop_delta_t delta;
  logic        delta_valid;
  logic        delta_ready;

  pcop_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // radius scaling of sin/cos, one request per cycle while the sequencer keeps up
  pcop_trig_scale #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk           (clk),
    .rst           (rst),
    .angle         (angle),
    .circle_radius (cfg.circle_radius),
    .delta_valid   (delta_valid),
    .delta_ready   (delta_ready),
    .delta         (delta)
  );

  // eight-way mirror about the centre
  pcop_point_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .delta_valid (delta_valid),
    .delta_ready (delta_ready),
    .delta       (delta),
    .cfg         (cfg),
    .point       (point)
  );
endmodule
`default_nettype wire

// ===== verif/parametric_circle_octant_points_test.sv =====
`timescale 1ns / 1ps
// Testbench for parametric_circle_octant_points: angle requests in, eight mirrored points out.
module parametric_circle_octant_points_test;
  import pcop_pkg::*;

  // Fraction bits of the sine/cosine words; the instance is built with the same value.
  localparam int FRAC_BITS = 15;

  // pi in Q2.30 and 1.0 in Q2.30, as the sine series expects them.
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  // Register slot past the last real one; writes there must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Quiet cycles after the last point before touching the registers or ending.
  localparam int SETTLE_CYCLES = 16;

  // Hard stop. Even ~270 requests * 8 points with random stalls and gaps stay far below this.
  localparam int CYCLE_LIMIT = 200000;

  localparam int COORD_MIN  = -2048;
  localparam int COORD_MAX  = 2047;
  localparam int RADIUS_MAX = 2047;

  typedef struct packed {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic                      last;
  } plot_point_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pcop_angle_if angle_ch ();
  pcop_point_if point_ch ();

  parametric_circle_octant_points #(
    .TRIG_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .angle   (angle_ch),
    .point   (point_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's registers, updated on each APB write to one of them.
  int          centre_x_shadow;
  int          centre_y_shadow;
  int          radius_shadow;

  // Points still owed by the block, oldest first.
  plot_point_t pending_points[$];
  plot_point_t head_point;

  int          mismatch_count;
  int          cycle_count;
  int          stall_left;
  bit          idle_en;       // random gaps on both channels while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Point predictor
  // ---------------------------------------------------------------------------

  // Sine of a whole degree: Taylor series to t^17 in Q2.30, products and
  // quotients truncated, clamped to [0, 1], rounded half-up to FRAC_BITS.
  function automatic logic [63:0] sine_fixed(input int deg);
    logic [63:0]        rad;
    logic [63:0]        rad_sq;
    logic [63:0]        term;
    logic [63:0]        mag;
    logic signed [63:0] acc;
    bit                 subtract;
    rad      = (64'(deg) * PI_Q30 + 64'd90) / 64'd180;   // degrees to radians, nearest
    rad_sq   = (rad * rad) >> 30;
    term     = rad;
    acc      = $signed(rad);
    subtract = 1'b1;
    for (int n = 2; n <= 16; n += 2) begin
      term = (term * rad_sq) >> 30;
      term = term / 64'(n * (n + 1));
      acc  = subtract ? acc - $signed(term) : acc + $signed(term);
      subtract = !subtract;
    end
    if (acc < 0) begin
      acc = '0;
    end
    mag = $unsigned(acc);
    if (mag > ONE_Q30) begin
      mag = ONE_Q30;
    end
    return (mag + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  endfunction

  // radius * trig, rounded up only when the fraction is strictly above a half
  function automatic int scaled_round(input int radius, input logic [63:0] trig);
    logic [63:0] prod;
    logic [63:0] whole;
    logic [63:0] frac;
    prod  = 64'(radius) * trig;
    whole = prod >> FRAC_BITS;
    frac  = prod & ((64'd1 << FRAC_BITS) - 64'd1);
    if (frac > (64'd1 << (FRAC_BITS - 1))) begin
      whole = whole + 64'd1;
    end
    return int'(whole);
  endfunction

  // Queue the eight mirrored points that one angle request must produce.
  function automatic void predict_octant_points(input logic [ANGLE_W-1:0] angle);
    int          deg;
    int          dx;
    int          dy;
    int          cx;
    int          cy;
    int          px[8];
    int          py[8];
    plot_point_t pt;
    deg = (angle > ANGLE_MAX) ? int'(ANGLE_MAX) : int'(angle);   // above 90 saturates
    dx  = scaled_round(radius_shadow, sine_fixed(int'(ANGLE_MAX) - deg));
    dy  = scaled_round(radius_shadow, sine_fixed(deg));
    cx  = centre_x_shadow;
    cy  = centre_y_shadow;
    px  = '{cx - dx, cx + dx, cx - dx, cx + dx, cx - dy, cx + dy, cx - dy, cx + dy};
    py  = '{cy + dy, cy + dy, cy - dy, cy - dy, cy + dx, cy + dx, cy - dx, cy - dx};
    for (int i = 0; i < 8; i++) begin
      pt.x    = POINT_W'(px[i]);
      pt.y    = POINT_W'(py[i]);
      pt.last = (i == 7);
      pending_points.push_back(pt);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One angle request. Valid stays high after acceptance; the next call either
  // reuses it or drops it for a gap, so valid sees one update per edge.
  task automatic send_angle(input logic [ANGLE_W-1:0] angle);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      angle_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    angle_ch.valid         <= 1'b1;
    angle_ch.angle_degrees <= angle;
    do @(posedge clk); while (!angle_ch.ready);
    predict_octant_points(angle);
  endtask

  // Stop sending and let every owed point drain, plus a few quiet cycles.
  task automatic wait_idle();
    angle_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then psel drops low again before returning.
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CENTRE_X: centre_x_shadow = int'($signed(value[COORD_W-1:0]));
      REG_CENTRE_Y: centre_y_shadow = int'($signed(value[COORD_W-1:0]));
      REG_RADIUS:   radius_shadow   = int'(value[RADIUS_W-1:0]);
      default: ;    // spare slot, no register behind it
    endcase
    @(posedge clk);
  endtask

  // Program all three registers; upper data bits carry junk the block must drop.
  task automatic set_config(input int cx, input int cy, input int radius);
    logic [DATA_W-1:0] word;
    wait_idle();
    word = $urandom();
    word[COORD_W-1:0] = cx[COORD_W-1:0];
    write_reg(REG_CENTRE_X, word);
    word = $urandom();
    word[COORD_W-1:0] = cy[COORD_W-1:0];
    write_reg(REG_CENTRE_Y, word);
    word = $urandom();
    word[RADIUS_W-1:0] = radius[RADIUS_W-1:0];
    write_reg(REG_RADIUS, word);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return int'($urandom_range(0, 4095)) + COORD_MIN;
    endcase
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return RADIUS_MAX;
      default: return int'($urandom_range(0, RADIUS_MAX));
    endcase
  endfunction

  // Mostly first-octant angles, now and then any 7-bit value.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    if ($urandom_range(0, 7) == 0) begin
      return ANGLE_W'($urandom_range(0, 127));
    end
    return ANGLE_W'($urandom_range(46, 90));
  endfunction

  task automatic random_config();
    set_config(pick_coord(), pick_coord(), pick_radius());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers untouched since reset: zero radius at the origin.
  task automatic test_reset_values();
    send_angle(ANGLE_MAX);
    send_angle(7'd46);
  endtask

  // Field extremes, out-of-range angles, the exact-half rounding edge, the
  // ignored register slot and zero radius away from the origin.
  task automatic test_extremes();
    logic [ANGLE_W-1:0] corner_angles[$];
    corner_angles = '{7'd90, 7'd46, 7'd45, 7'd0, 7'd1, 7'd91, 7'd127, 7'd64, 7'd63};
    set_config(COORD_MIN, COORD_MAX, RADIUS_MAX);
    foreach (corner_angles[i]) begin
      send_angle(corner_angles[i]);
    end
    set_config(COORD_MAX, COORD_MIN, RADIUS_MAX);
    send_angle(7'd90);
    send_angle(7'd46);
    // radius 1: sin 30 is exactly one half and must round down
    set_config(0, 0, 1);
    send_angle(7'd30);
    send_angle(7'd31);
    send_angle(7'd60);
    send_angle(7'd89);
    wait_idle();
    write_reg(REG_SPARE, $urandom());
    send_angle(7'd46);
    set_config(-1, 1, 0);
    send_angle(7'd75);
    send_angle(7'd100);
  endtask

  // Whole circle, 90 down to 46, on a random setting.
  task automatic test_octant_sweep();
    random_config();
    for (int a = 90; a >= 46; a--) begin
      send_angle(ANGLE_W'(a));
    end
  endtask

  // Random angles over several settings, gaps on in most phases.
  task automatic test_random_angles();
    for (int phase = 0; phase < 4; phase++) begin
      idle_en = (phase != 2);
      random_config();
      repeat (40) send_angle(pick_angle());
    end
  endtask

  // Closing stretch at full rate: no gaps, no stalls.
  task automatic test_back_to_back();
    random_config();
    idle_en = 1'b0;
    for (int a = 90; a >= 46; a--) begin
      send_angle(($urandom_range(0, 3) == 0) ? pick_angle() : ANGLE_W'(a));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Point sink: random stall bursts while gaps are enabled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left        <= stall_left - 1;
      point_ch.ready    <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left        <= $urandom_range(0, 3);
      point_ch.ready    <= 1'b0;
    end else begin
      point_ch.ready    <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Point checker: every accepted point against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && point_ch.valid && point_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point: point_x %0d point_y %0d last_point %0d",
               point_ch.point_x, point_ch.point_y, point_ch.last_point);
        mismatch_count++;
      end else begin
        head_point = pending_points.pop_front();
        if (point_ch.point_x !== head_point.x) begin
          $error("point_x: expected %0d, got %0d", head_point.x, point_ch.point_x);
          mismatch_count++;
        end
        if (point_ch.point_y !== head_point.y) begin
          $error("point_y: expected %0d, got %0d", head_point.y, point_ch.point_y);
          mismatch_count++;
        end
        if (point_ch.last_point !== head_point.last) begin
          $error("last_point: expected %0d, got %0d", head_point.last, point_ch.last_point);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("parametric_circle_octant_points verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    angle_ch.valid         = 1'b0;
    angle_ch.angle_degrees = '0;
    point_ch.ready         = 1'b0;
    centre_x_shadow        = 0;
    centre_y_shadow        = 0;
    radius_shadow          = 0;
    mismatch_count         = 0;
    cycle_count            = 0;
    stall_left             = 0;
    idle_en                = 1'b1;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_extremes();
    test_octant_sweep();
    test_random_angles();
    test_back_to_back();

    // all owed points in, then a quiet tail to catch strays
    wait_idle();
    if (mismatch_count == 0) begin
      $display("parametric_circle_octant_points verification clean");
    end else begin
      $display("parametric_circle_octant_points verification failed");
    end
    $finish;
  end

endmodule
